FILE: rtl/core/tbhu_pkg.sv
package tbhu_pkg;

   localparam int GRID_SIZE = 1024;
   localparam int CELL_W    = 10;
   localparam int POS_W     = 19;
   localparam int SQ_W      = 2 * POS_W;
   localparam int D2_W      = SQ_W + 1;
   localparam int REM_W     = D2_W + 1;
   localparam int FRAC_W    = 16;
   localparam int WEIGHT_W  = 31;
   localparam int HEIGHT_W  = 32;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 32;
   localparam int DIV_STAGES = FRAC_W;
   localparam int SPAN_W    = 17;
   localparam logic [SPAN_W-1:0] GRID_MAX = SPAN_W'(GRID_SIZE - 1);

   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTER_R    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_R    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE       = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_AVG_HEIGHT = 3'd6;

   localparam logic [2:0] MODE_RAISE   = 3'd0;
   localparam logic [2:0] MODE_LOWER   = 3'd1;
   localparam logic [2:0] MODE_FLATTEN = 3'd2;
   localparam logic [2:0] MODE_SMOOTH  = 3'd3;

   typedef struct packed {
      logic [CELL_W-1:0]          cell_x;
      logic [CELL_W-1:0]          cell_y;
      logic signed [HEIGHT_W-1:0] current_height;
   } req_type;

   typedef struct packed {
      logic signed [HEIGHT_W-1:0] result_height;
      logic                       in_area;
      logic                       bad_mode;
   } rsp_type;

   typedef struct packed {
      logic [POS_W-1:0]           center_x;
      logic [POS_W-1:0]           center_y;
      logic [POS_W-1:0]           outer_radius;
      logic [POS_W-1:0]           inner_radius;
      logic [WEIGHT_W-1:0]        brush_weight;
      logic [2:0]                 brush_mode;
      logic signed [HEIGHT_W-1:0] target_height;
   } cfg_type;

   // classified cell handed from front to back
   typedef struct packed {
      logic signed [HEIGHT_W-1:0] current_height;
      logic                       in_area;
      logic [POS_W-1:0]           dx;
      logic [POS_W-1:0]           dy;
   } item_type;

endpackage

FILE: rtl/core/tbhu_front.sv
module tbhu_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  tbhu_pkg::req_type  in_req,
   input  tbhu_pkg::cfg_type  cfg,
   output logic               out_valid,
   output tbhu_pkg::item_type out_item
);

   logic [tbhu_pkg::SPAN_W-1:0] left, right, top, bottom;
   logic [tbhu_pkg::SPAN_W-1:0] cx_s, cy_s, hi_x, hi_y;
   logic [tbhu_pkg::POS_W:0]    sum_x, sum_y;
   logic [tbhu_pkg::POS_W-1:0]  px, py;
   logic                        area;
   logic                        valid_ff;
   tbhu_pkg::item_type          item_ff, item_in;

   always_comb begin
      sum_x = {1'b0, cfg.center_x} + {1'b0, cfg.outer_radius};
      sum_y = {1'b0, cfg.center_y} + {1'b0, cfg.outer_radius};
      hi_x  = tbhu_pkg::SPAN_W'(sum_x[tbhu_pkg::POS_W:8]);
      hi_y  = tbhu_pkg::SPAN_W'(sum_y[tbhu_pkg::POS_W:8]);
      cx_s  = (cfg.center_x >= cfg.outer_radius) ?
              tbhu_pkg::SPAN_W'(((cfg.center_x - cfg.outer_radius) >> 8)) : '0;
      cy_s  = (cfg.center_y >= cfg.outer_radius) ?
              tbhu_pkg::SPAN_W'(((cfg.center_y - cfg.outer_radius) >> 8)) : '0;
      left   = cx_s;
      top    = cy_s;
      right  = (hi_x > tbhu_pkg::GRID_MAX) ? tbhu_pkg::GRID_MAX : hi_x;
      bottom = (hi_y > tbhu_pkg::GRID_MAX) ? tbhu_pkg::GRID_MAX : hi_y;
      area = (tbhu_pkg::SPAN_W'(in_req.cell_x) >= left)
          && (tbhu_pkg::SPAN_W'(in_req.cell_x) <= right)
          && (tbhu_pkg::SPAN_W'(in_req.cell_y) >= top)
          && (tbhu_pkg::SPAN_W'(in_req.cell_y) <= bottom);
      px = {1'b0, in_req.cell_x, 8'd0};
      py = {1'b0, in_req.cell_y, 8'd0};
      item_in.current_height = in_req.current_height;
      item_in.in_area        = area;
      item_in.dx = (px >= cfg.center_x) ? px - cfg.center_x : cfg.center_x - px;
      item_in.dy = (py >= cfg.center_y) ? py - cfg.center_y : cfg.center_y - py;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

FILE: rtl/core/tbhu_queue.sv
module tbhu_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  tbhu_pkg::item_type push_item,
   input  logic               pop,
   output logic               not_empty,
   output logic               full,
   output tbhu_pkg::item_type head
);

   tbhu_pkg::item_type slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;
   logic       do_pop, do_push;

   always_comb begin
      do_pop   = pop && (count_ff != 2'd0);
      do_push  = push && (count_ff != 2'd2);
      count_in = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) wr_ptr_ff <= ~wr_ptr_ff;
         if (do_pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_in;
      end
      if (do_push) slot_ff[wr_ptr_ff] <= push_item;
   end

   assign not_empty = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign head      = slot_ff[rd_ptr_ff];

endmodule

FILE: rtl/core/tbhu_back.sv
module tbhu_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  tbhu_pkg::item_type in_item,
   input  tbhu_pkg::cfg_type  cfg,
   output logic               out_valid,
   output tbhu_pkg::rsp_type  out_rsp
);

   localparam int NS = tbhu_pkg::DIV_STAGES;

   // squares
   logic                             v1_ff;
   logic [tbhu_pkg::SQ_W-1:0]        dx2_ff, dy2_ff, in2_ff, out2_sq_ff;
   logic signed [tbhu_pkg::HEIGHT_W-1:0] cur1_ff;
   logic                             area1_ff;

   // distance compare
   logic                             v2_ff;
   logic [tbhu_pkg::D2_W-1:0]        d2_ff;
   logic                             le_in2_ff, ge_out2_ff;
   logic [tbhu_pkg::SQ_W-1:0]        out2b_ff;
   logic signed [tbhu_pkg::HEIGHT_W-1:0] cur2_ff;
   logic                             area2_ff;
   logic [tbhu_pkg::D2_W-1:0]        d2_in;

   // divider pipeline
   logic                             dv_ff    [NS];
   logic [tbhu_pkg::REM_W-1:0]       rem_ff   [NS];
   logic [NS-1:0]                    quo_ff   [NS];
   logic [tbhu_pkg::SQ_W-1:0]        dsr_ff   [NS];
   logic                             dle_ff   [NS];
   logic                             dge_ff   [NS];
   logic signed [tbhu_pkg::HEIGHT_W-1:0] dcur_ff [NS];
   logic                             darea_ff [NS];

   // falloff and product
   logic                             vf_ff, vm_ff, vo_ff;
   logic [tbhu_pkg::FRAC_W:0]        f_ff, f_in;
   logic signed [tbhu_pkg::HEIGHT_W-1:0] curf_ff, curm_ff;
   logic                             areaf_ff, aream_ff;
   logic [tbhu_pkg::HEIGHT_W-1:0]    added_ff;
   logic [tbhu_pkg::WEIGHT_W+tbhu_pkg::FRAC_W:0] prod;
   tbhu_pkg::rsp_type                rsp_ff, rsp_in;
   logic signed [tbhu_pkg::HEIGHT_W+1:0] sum_s;
   logic                             do_add, bad;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      dx2_ff     <= in_item.dx * in_item.dx;
      dy2_ff     <= in_item.dy * in_item.dy;
      in2_ff     <= cfg.inner_radius * cfg.inner_radius;
      out2_sq_ff <= cfg.outer_radius * cfg.outer_radius;
      cur1_ff    <= in_item.current_height;
      area1_ff   <= in_item.in_area;

      d2_ff      <= d2_in;
      le_in2_ff  <= d2_in <= {1'b0, in2_ff};
      ge_out2_ff <= (out2_sq_ff == '0) || (d2_in >= {1'b0, out2_sq_ff});
      out2b_ff   <= out2_sq_ff;
      cur2_ff    <= cur1_ff;
      area2_ff   <= area1_ff;
   end

   assign d2_in = {1'b0, dx2_ff} + {1'b0, dy2_ff};

   // restoring division, one quotient bit per stage
   for (genvar i = 0; i < NS; i++) begin : g_div
      logic [tbhu_pkg::REM_W-1:0] r_prev, r_sh;
      logic [NS-1:0]              q_prev;
      logic [tbhu_pkg::SQ_W-1:0]  dsr;
      logic                       v_prev, le_prev, ge_prev, area_prev, take;
      logic signed [tbhu_pkg::HEIGHT_W-1:0] cur_prev;

      if (i == 0) begin : g_first
         always_comb begin
            r_prev    = {1'b0, d2_ff};
            q_prev    = '0;
            dsr       = out2b_ff;
            v_prev    = v2_ff;
            le_prev   = le_in2_ff;
            ge_prev   = ge_out2_ff;
            cur_prev  = cur2_ff;
            area_prev = area2_ff;
         end
      end else begin : g_next
         always_comb begin
            r_prev    = rem_ff[i-1];
            q_prev    = quo_ff[i-1];
            dsr       = dsr_ff[i-1];
            v_prev    = dv_ff[i-1];
            le_prev   = dle_ff[i-1];
            ge_prev   = dge_ff[i-1];
            cur_prev  = dcur_ff[i-1];
            area_prev = darea_ff[i-1];
         end
      end

      always_comb begin
         r_sh = {r_prev[tbhu_pkg::REM_W-2:0], 1'b0};
         take = r_sh >= {2'b00, dsr};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[i] <= 1'b0;
         end else begin
            dv_ff[i] <= v_prev;
         end
         rem_ff[i]   <= take ? r_sh - {2'b00, dsr} : r_sh;
         quo_ff[i]   <= {q_prev[NS-2:0], take};
         dsr_ff[i]   <= dsr;
         dle_ff[i]   <= le_prev;
         dge_ff[i]   <= ge_prev;
         dcur_ff[i]  <= cur_prev;
         darea_ff[i] <= area_prev;
      end
   end

   always_comb begin
      priority if (dle_ff[NS-1]) begin
         f_in = {1'b1, {tbhu_pkg::FRAC_W{1'b0}}};
      end else if (dge_ff[NS-1]) begin
         f_in = '0;
      end else begin
         f_in = {1'b1, {tbhu_pkg::FRAC_W{1'b0}}} - {1'b0, quo_ff[NS-1]};
      end
      prod = cfg.brush_weight * f_ff;
   end

   always_comb begin
      unique case (cfg.brush_mode)
         tbhu_pkg::MODE_RAISE:   begin do_add = 1'b1; bad = 1'b0; end
         tbhu_pkg::MODE_LOWER:   begin do_add = 1'b0; bad = 1'b0; end
         tbhu_pkg::MODE_FLATTEN,
         tbhu_pkg::MODE_SMOOTH:  begin
            do_add = curm_ff < cfg.target_height;
            bad    = 1'b0;
         end
         default:                begin do_add = 1'b0; bad = 1'b1; end
      endcase
      sum_s = do_add ? {{2{curm_ff[tbhu_pkg::HEIGHT_W-1]}}, curm_ff} + {2'b00, added_ff}
                     : {{2{curm_ff[tbhu_pkg::HEIGHT_W-1]}}, curm_ff} - {2'b00, added_ff};
      rsp_in.in_area  = aream_ff;
      rsp_in.bad_mode = aream_ff && bad;
      if (!aream_ff || bad) begin
         rsp_in.result_height = curm_ff;
      end else if (sum_s > 34'sh0_7FFF_FFFF) begin
         rsp_in.result_height = 32'sh7FFF_FFFF;
      end else if (sum_s < -34'sh0_8000_0000) begin
         rsp_in.result_height = 32'sh8000_0000;
      end else begin
         rsp_in.result_height = sum_s[tbhu_pkg::HEIGHT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vf_ff <= 1'b0;
         vm_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         vf_ff <= dv_ff[NS-1];
         vm_ff <= vf_ff;
         vo_ff <= vm_ff;
      end
      f_ff     <= f_in;
      curf_ff  <= dcur_ff[NS-1];
      areaf_ff <= darea_ff[NS-1];
      added_ff <= prod[tbhu_pkg::WEIGHT_W+tbhu_pkg::FRAC_W:tbhu_pkg::FRAC_W];
      curm_ff  <= curf_ff;
      aream_ff <= areaf_ff;
      rsp_ff   <= rsp_in;
   end

   assign out_valid = vo_ff;
   assign out_rsp   = rsp_ff;

endmodule

FILE: rtl/core/terrain_brush_height_update_core.sv
// throughput: one request per cycle while busy is low, every stage including the 16-stage falloff divider is pipelined
// busy only rises if the front-to-back queue fills, which a free-running back never lets happen
// results are strobed for one cycle; the receiver cannot stall
// synchronous active-high reset zeroes the brush registers and clears the valid pipeline
module terrain_brush_height_update_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  tbhu_pkg::req_type                req_data,
   output logic                             rsp_strobe,
   output tbhu_pkg::rsp_type                rsp_data,
   input  logic                             csr_we,
   input  logic [tbhu_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tbhu_pkg::CSR_DAT_W-1:0]   csr_wdata
);

   tbhu_pkg::cfg_type  cfg_ff;
   tbhu_pkg::item_type front_item, head_item;
   logic               front_valid, q_not_empty, q_full, accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            tbhu_pkg::CSR_CENTER_X:   cfg_ff.center_x     <= csr_wdata[tbhu_pkg::POS_W-1:0];
            tbhu_pkg::CSR_CENTER_Y:   cfg_ff.center_y     <= csr_wdata[tbhu_pkg::POS_W-1:0];
            tbhu_pkg::CSR_OUTER_R:    cfg_ff.outer_radius <= csr_wdata[tbhu_pkg::POS_W-1:0];
            tbhu_pkg::CSR_INNER_R:    cfg_ff.inner_radius <= csr_wdata[tbhu_pkg::POS_W-1:0];
            tbhu_pkg::CSR_WEIGHT:     cfg_ff.brush_weight <= csr_wdata[tbhu_pkg::WEIGHT_W-1:0];
            tbhu_pkg::CSR_MODE:       cfg_ff.brush_mode   <= csr_wdata[2:0];
            tbhu_pkg::CSR_AVG_HEIGHT: cfg_ff.target_height <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign busy   = q_full;
   assign accept = start && !q_full;

   tbhu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_req    (req_data),
      .cfg       (cfg_ff),
      .out_valid (front_valid),
      .out_item  (front_item)
   );

   tbhu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_item (front_item),
      .pop       (1'b1),
      .not_empty (q_not_empty),
      .full      (q_full),
      .head      (head_item)
   );

   tbhu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_not_empty),
      .in_item   (head_item),
      .cfg       (cfg_ff),
      .out_valid (rsp_strobe),
      .out_rsp   (rsp_data)
   );

endmodule

FILE: tb/tb_terrain_brush_height_update_core.sv
`timescale 1ns / 1ps

module tb_terrain_brush_height_update_core;

   localparam int LATENCY    = 23;
   localparam int STALL_MAX  = 2000;
   localparam int N_RANDOM   = 600;

   logic                           clock;
   logic                           reset;
   logic                           start;
   logic                           busy;
   tbhu_pkg::req_type              req_data;
   logic                           rsp_strobe;
   tbhu_pkg::rsp_type              rsp_data;
   logic                           csr_we;
   logic [tbhu_pkg::CSR_IDX_W-1:0] csr_index;
   logic [tbhu_pkg::CSR_DAT_W-1:0] csr_wdata;

   terrain_brush_height_update_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // shadow of the brush settings
   logic [tbhu_pkg::POS_W-1:0]           brush_cx, brush_cy, brush_outer, brush_inner;
   logic [tbhu_pkg::WEIGHT_W-1:0]        brush_wt;
   logic [2:0]                           brush_md;
   logic signed [tbhu_pkg::HEIGHT_W-1:0] brush_avg;

   tbhu_pkg::rsp_type heights_due[$];
   int      errors;
   int      idle_cycles;
   int      send_idle_pct;

   typedef struct {
      logic [tbhu_pkg::CELL_W-1:0]          x;
      logic [tbhu_pkg::CELL_W-1:0]          y;
      logic signed [tbhu_pkg::HEIGHT_W-1:0] h;
      bit                                   fixed;
      tbhu_pkg::rsp_type                    want;
   } cell_row_type;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic tbhu_pkg::rsp_type brush_height(tbhu_pkg::req_type c);
      tbhu_pkg::rsp_type r;
      logic [63:0] l, rt, t, b, top, p, d, d2, in2, out2, f, added;
      longint     h, cur;
      cur = longint'(c.current_height);
      h = cur;
      r.bad_mode = 1'b0;
      top = (64'(brush_cx) + brush_outer) >> 8;
      l  = (brush_cx >= brush_outer) ? (64'(brush_cx) - brush_outer) >> 8 : 0;
      rt = (top > tbhu_pkg::GRID_SIZE - 1) ? 64'(tbhu_pkg::GRID_SIZE - 1) : top;
      top = (64'(brush_cy) + brush_outer) >> 8;
      t  = (brush_cy >= brush_outer) ? (64'(brush_cy) - brush_outer) >> 8 : 0;
      b  = (top > tbhu_pkg::GRID_SIZE - 1) ? 64'(tbhu_pkg::GRID_SIZE - 1) : top;
      r.in_area = (c.cell_x >= l) && (c.cell_x <= rt) && (c.cell_y >= t) && (c.cell_y <= b);
      if (r.in_area) begin
         p = 64'(c.cell_x) << 8;
         d = (p >= brush_cx) ? p - brush_cx : brush_cx - p;
         d2 = d * d;
         p = 64'(c.cell_y) << 8;
         d = (p >= brush_cy) ? p - brush_cy : brush_cy - p;
         d2 = d2 + d * d;
         in2 = 64'(brush_inner) * brush_inner;
         out2 = 64'(brush_outer) * brush_outer;
         if (d2 <= in2) f = 65536;
         else if (out2 == 0 || d2 >= out2) f = 0;
         else f = 65536 - (d2 << 16) / out2;
         added = (64'(brush_wt) * f) >> 16;
         case (brush_md)
            tbhu_pkg::MODE_RAISE: h = cur + longint'(added);
            tbhu_pkg::MODE_LOWER: h = cur - longint'(added);
            tbhu_pkg::MODE_FLATTEN, tbhu_pkg::MODE_SMOOTH: begin
               if (cur < longint'(brush_avg)) h = cur + longint'(added);
               else h = cur - longint'(added);
            end
            default: r.bad_mode = 1'b1;
         endcase
         if (h > 64'sh7FFFFFFF) h = 64'sh7FFFFFFF;
         if (h < -64'sh80000000) h = -64'sh80000000;
      end
      r.result_height = h[31:0];
      return r;
   endfunction

   task automatic report(string what, tbhu_pkg::rsp_type got, tbhu_pkg::rsp_type want);
      $display("mismatch %s: got h=%0d a=%0b b=%0b want h=%0d a=%0b b=%0b", what,
               got.result_height, got.in_area, got.bad_mode,
               want.result_height, want.in_area, want.bad_mode);
      errors++;
   endtask

   // result checker, also the stall watchdog
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((start && !busy) || rsp_strobe) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > STALL_MAX) begin
            $display("Test completed with failures");
            $finish;
         end
         if (rsp_strobe) begin
            if (heights_due.size() == 0) report("unexpected", rsp_data, rsp_data);
            else if (rsp_data !== heights_due[0]) begin
               report("result", rsp_data, heights_due[0]);
               void'(heights_due.pop_front());
            end else void'(heights_due.pop_front());
         end
      end
   end

   task automatic write_reg(logic [tbhu_pkg::CSR_IDX_W-1:0] idx,
                            logic [tbhu_pkg::CSR_DAT_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         tbhu_pkg::CSR_CENTER_X:   brush_cx = val[tbhu_pkg::POS_W-1:0];
         tbhu_pkg::CSR_CENTER_Y:   brush_cy = val[tbhu_pkg::POS_W-1:0];
         tbhu_pkg::CSR_OUTER_R:    brush_outer = val[tbhu_pkg::POS_W-1:0];
         tbhu_pkg::CSR_INNER_R:    brush_inner = val[tbhu_pkg::POS_W-1:0];
         tbhu_pkg::CSR_WEIGHT:     brush_wt = val[tbhu_pkg::WEIGHT_W-1:0];
         tbhu_pkg::CSR_MODE:       brush_md = val[2:0];
         tbhu_pkg::CSR_AVG_HEIGHT: brush_avg = val;
         default: ;
      endcase
   endtask

   task automatic drain();
      start <= 1'b0;
      while (heights_due.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic set_brush(logic [tbhu_pkg::POS_W-1:0] cx, logic [tbhu_pkg::POS_W-1:0] cy,
                            logic [tbhu_pkg::POS_W-1:0] ro, logic [tbhu_pkg::POS_W-1:0] ri,
                            logic [tbhu_pkg::WEIGHT_W-1:0] wt, logic [2:0] md,
                            logic [tbhu_pkg::HEIGHT_W-1:0] avg);
      drain();
      write_reg(tbhu_pkg::CSR_CENTER_X, 32'(cx));
      write_reg(tbhu_pkg::CSR_CENTER_Y, 32'(cy));
      write_reg(tbhu_pkg::CSR_OUTER_R, 32'(ro));
      write_reg(tbhu_pkg::CSR_INNER_R, 32'(ri));
      write_reg(tbhu_pkg::CSR_WEIGHT, 32'(wt));
      write_reg(tbhu_pkg::CSR_MODE, 32'(md));
      write_reg(tbhu_pkg::CSR_AVG_HEIGHT, avg);
      csr_we <= 1'b0;
   endtask

   // start stays high after the accepting edge; the next request reuses it, and drain or an idle gap drops it
   task automatic send_cell(tbhu_pkg::req_type c, bit fixed, tbhu_pkg::rsp_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= c;
      heights_due.push_back(fixed ? want : brush_height(c));
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   function automatic logic [tbhu_pkg::POS_W-1:0] rand_pos();
      case ($urandom_range(3))
         0: return tbhu_pkg::POS_W'($urandom_range(262143));
         1: return tbhu_pkg::POS_W'({$urandom_range(1023), 8'($urandom)});
         2: return '1;
         default: return tbhu_pkg::POS_W'($urandom_range(4095));
      endcase
   endfunction

   function automatic logic [tbhu_pkg::CELL_W-1:0] near(logic [tbhu_pkg::POS_W-1:0] c,
                                                        logic [tbhu_pkg::POS_W-1:0] r);
      int base, span;
      base = int'(c >> 8);
      span = int'(r >> 8) + 2;
      return tbhu_pkg::CELL_W'(base + $urandom_range(2 * span) - span);
   endfunction

   cell_row_type rows[$];

   initial begin
      tbhu_pkg::req_type c;
      int      n;
      errors = 0;
      send_idle_pct = 0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      {brush_cx, brush_cy, brush_outer, brush_inner} = '0;
      brush_wt = '0;
      brush_md = tbhu_pkg::MODE_RAISE;
      brush_avg = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // after reset: zero radius square covers cell (0,0) only, weight zero
      rows.push_back('{10'd0, 10'd0, 32'sh7FFFFFFF, 1, '{32'sh7FFFFFFF, 1'b1, 1'b0}});
      rows.push_back('{10'd1, 10'd0, 32'sd5, 1, '{32'sd5, 1'b0, 1'b0}});
      rows.push_back('{10'd1023, 10'd1023, -32'sh80000000, 1,
                       '{-32'sh80000000, 1'b0, 1'b0}});
      foreach (rows[i]) begin
         c = '{rows[i].x, rows[i].y, rows[i].h};
         send_cell(c, rows[i].fixed, rows[i].want);
      end
      rows.delete();

      // full strength raise centered mid grid, saturation at the top
      set_brush(19'd512 << 8, 19'd512 << 8, 19'd8 << 8, 19'd2 << 8, '1,
                tbhu_pkg::MODE_RAISE, 32'd0);
      rows.push_back('{10'd512, 10'd512, 32'sh7FFFFFFF, 1, '{32'sh7FFFFFFF, 1'b1, 1'b0}});
      rows.push_back('{10'd512, 10'd512, 32'sd0, 1, '{32'sh7FFFFFFF, 1'b1, 1'b0}});
      rows.push_back('{10'd515, 10'd515, 32'sd7, 0, '{0, 0, 0}});
      rows.push_back('{10'd519, 10'd512, 32'sd7, 0, '{0, 0, 0}});
      rows.push_back('{10'd521, 10'd512, 32'sd7, 1, '{32'sd7, 1'b0, 1'b0}});
      foreach (rows[i]) begin
         c = '{rows[i].x, rows[i].y, rows[i].h};
         send_cell(c, rows[i].fixed, rows[i].want);
      end
      rows.delete();

      // lower saturating at the bottom, then flatten, smooth and the unused modes 4 to 7 on both sides of average
      set_brush(19'd512 << 8, 19'd512 << 8, 19'd8 << 8, 19'd2 << 8, '1,
                tbhu_pkg::MODE_LOWER, 32'd0);
      rows.push_back('{10'd512, 10'd512, -32'sh80000000, 1,
                       '{-32'sh80000000, 1'b1, 1'b0}});
      rows.push_back('{10'd514, 10'd510, 32'sd100, 0, '{0, 0, 0}});
      foreach (rows[i]) begin
         c = '{rows[i].x, rows[i].y, rows[i].h};
         send_cell(c, rows[i].fixed, rows[i].want);
      end
      rows.delete();
      for (int m = tbhu_pkg::MODE_FLATTEN; m <= 7; m++) begin
         set_brush(19'd3 << 8, 19'd1020 << 8, 19'd5 << 8, 19'd1 << 8, 31'h10000, 3'(m),
                   32'sd1000);
         send_cell('{10'd3, 10'd1023, 32'sd999}, 0, '0);
         send_cell('{10'd5, 10'd1020, 32'sd1000}, 0, '0);
         send_cell('{10'd0, 10'd1022, -32'sd5}, 0, '0);
         send_cell('{10'd20, 10'd1022, -32'sd5}, 0, '0);
      end
      // inner radius beyond outer, and zero outer radius with nonzero inner
      set_brush(19'd100 << 8, 19'd100 << 8, 19'd2 << 8, 19'd9 << 8, 31'h30000,
                tbhu_pkg::MODE_RAISE, 0);
      send_cell('{10'd102, 10'd101, 32'sd0}, 0, '0);
      set_brush(19'd100 << 8, 19'd100 << 8, 19'd0, 19'd1 << 8, 31'h30000,
                tbhu_pkg::MODE_RAISE, 0);
      send_cell('{10'd100, 10'd100, 32'sd0}, 0, '0);

      // random part in three idle phases
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 24 : (ph == 1) ? 80 : 0;
         n = 0;
         while (n < N_RANDOM / 3) begin
            set_brush(rand_pos(), rand_pos(),
                      ($urandom_range(3) == 0) ? rand_pos()
                                               : tbhu_pkg::POS_W'($urandom_range(8191)),
                      ($urandom_range(3) == 0) ? rand_pos()
                                               : tbhu_pkg::POS_W'($urandom_range(2047)),
                      ($urandom_range(4) == 0) ? '1 : tbhu_pkg::WEIGHT_W'($urandom),
                      3'($urandom_range(7)), $urandom);
            for (int k = 0; k < 25; k++) begin
               if ($urandom_range(4) != 0)
                  c = '{near(brush_cx, brush_outer), near(brush_cy, brush_outer), $urandom};
               else
                  c = '{tbhu_pkg::CELL_W'($urandom), tbhu_pkg::CELL_W'($urandom), $urandom};
               if ($urandom_range(9) == 0)
                  c.current_height = $urandom_range(1) ? '1 << 31 : ~('1 << 31);
               send_cell(c, 0, '0);
               n++;
            end
            // hold off until everything sent has come back
            if (ph == 2) begin
               start <= 1'b0;
               while (heights_due.size() != 0) @(posedge clock);
            end
         end
      end

      drain();
      if (errors == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule
